// File: rtl/rmrv_pkg.sv
// ----------------------------------------------------------------------------
// rmrv_pkg
// Shared types, codes and constant tables for the rotation vector pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rmrv_pkg;

  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_FRAC_BITS     = 14;
  localparam int ATAN_LEN          = 24;

  localparam int TOL_W   = 15;
  localparam int EPS_W   = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DET_TOL   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_EPS = 4'd1;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_DET = 2'd1;
  localparam logic [1:0] STATUS_PI  = 2'd2;

  // atan(2^-i) in Q30
  localparam longint ATAN_Q30 [ATAN_LEN] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };
  localparam longint HALF_PI_Q30 = 1686629713;

  typedef enum logic [1:0] {
    MODE_DIV,
    MODE_ZERO,
    MODE_SAT,
    MODE_FAIL
  } rmrv_mode_t;

  // control group that walks down the pipeline with each transaction
  typedef struct packed {
    logic              valid;
    logic              fail;
    logic              zs;
    logic              cpos;
    rmrv_mode_t        mode;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] dz;
  } rmrv_ctl_t;

  function automatic longint q30_to_f(longint v, int frac_bits);
    q30_to_f = (v + (64'sd1 <<< (29 - frac_bits))) >>> (30 - frac_bits);
  endfunction

  function automatic longint atan_f(int idx, int frac_bits);
    atan_f = q30_to_f(ATAN_Q30[idx], frac_bits);
  endfunction

  function automatic longint half_pi_f(int frac_bits);
    half_pi_f = q30_to_f(HALF_PI_Q30, frac_bits);
  endfunction

  function automatic longint pi_q13(int frac_bits);
    longint p;
    p = 2 * half_pi_f(frac_bits);
    if (frac_bits > 13) begin
      pi_q13 = (p + (64'sd1 <<< (frac_bits - 14))) >>> (frac_bits - 13);
    end else begin
      pi_q13 = p <<< (13 - frac_bits);
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/rmrv_if.sv
// ----------------------------------------------------------------------------
// rmrv_if
// Valid/ready channels: matrix input, rotation vector output, register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmrv_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00;
  logic signed [15:0] m01;
  logic signed [15:0] m02;
  logic signed [15:0] m10;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m20;
  logic signed [15:0] m21;
  logic signed [15:0] m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface rmrv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rot_x;
  logic signed [15:0] rot_y;
  logic signed [15:0] rot_z;
  logic [1:0]         status;
  modport source (output valid, rot_x, rot_y, rot_z, status, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, status, output ready);
endinterface

interface rmrv_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/rotation_matrix_to_rotation_vector.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_rotation_vector
// Q2.14 rotation matrix in, Q3.13 axis-angle rotation vector and status out.
// ----------------------------------------------------------------------------
// One transaction per clock sustained: every matrix enters a fixed pipeline of
// 5 + (FRAC_BITS+1) + 1 + CORDIC_STAGES + 2 + 16 + 1 register stages (56 at
// the defaults). The pipeline holds as a whole while a result waits at the
// output register and out_ch.ready is low; in_ch.ready follows that stall.
// Flow: determinant check (products, minors, cofactor terms, sum, tolerance),
// cosine and sine^2, a square root of one bit per cell, a vectoring CORDIC of
// one micro-rotation per cell, then three parallel restoring dividers of one
// quotient bit per cell. Register writes take effect at once and belong only
// to idle periods. Status 1 means the determinant is out of tolerance (zero
// vector), status 2 means the angle is within angle_epsilon of pi (components
// saturate by the sign of the skew differences).
`default_nettype none

module rotation_matrix_to_rotation_vector import rmrv_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
  parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rmrv_in_if.sink     in_ch,
  rmrv_out_if.source  out_ch,
  rmrv_cfg_if.sink    cfg_ch
);

  localparam int F    = FRAC_BITS;
  localparam int N    = CORDIC_STAGES;
  localparam int CFW  = F + 2;
  localparam int RADW = 2*F + 1;
  localparam int SFW  = F + 1;
  localparam int XW   = F + 4;
  localparam int NW   = F + 35;
  localparam int DW   = F + 16;
  localparam int TW   = XW + 4;
  localparam int CSR  = (F < 15) ? 15 - F : 0;
  localparam int CSL  = (F > 15) ? F - 15 : 0;
  localparam int SHR  = (F > 13) ? F - 13 : 0;
  localparam int SHL  = (F < 13) ? 13 - F : 0;
  localparam logic [TW-1:0] RND = (F > 13) ? TW'(1) << (SHR - 1) : '0;
  localparam logic signed [XW-1:0] HALF_PI = XW'(half_pi_f(F));
  localparam logic [16:0] PI13 = 17'(pi_q13(F));
  localparam logic signed [15:0] ROT_MAX = 16'sh7fff;
  localparam logic signed [15:0] ROT_MIN = 16'sh8000;

  // ---------------------------------------------------------------- config
  logic [TOL_W-1:0] det_tol_r;
  logic [EPS_W-1:0] ang_eps_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_tol_r <= TOL_W'(16);
      ang_eps_r <= EPS_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DET_TOL:   det_tol_r <= cfg_ch.data[TOL_W-1:0];
        REG_ANGLE_EPS: ang_eps_r <= cfg_ch.data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  // One enable for the whole chain: advance unless the output is stuck.
  logic out_v_r;
  logic en;
  logic in_acc;

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;
  assign in_acc      = in_ch.valid && en;

  // ------------------------------------------------ stage 1: 2x2 products
  logic               v1_r;
  logic signed [15:0] m_r [9];
  logic signed [31:0] p_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_acc;
    end
    if (en) begin
      m_r[0] <= in_ch.m00; m_r[1] <= in_ch.m01; m_r[2] <= in_ch.m02;
      m_r[3] <= in_ch.m10; m_r[4] <= in_ch.m11; m_r[5] <= in_ch.m12;
      m_r[6] <= in_ch.m20; m_r[7] <= in_ch.m21; m_r[8] <= in_ch.m22;
      p_r[0] <= in_ch.m11 * in_ch.m22;
      p_r[1] <= in_ch.m12 * in_ch.m21;
      p_r[2] <= in_ch.m10 * in_ch.m22;
      p_r[3] <= in_ch.m12 * in_ch.m20;
      p_r[4] <= in_ch.m10 * in_ch.m21;
      p_r[5] <= in_ch.m11 * in_ch.m20;
    end
  end

  // --------------------------- stage 2: minors, skew differences, cosine
  rmrv_ctl_t          ctl2_nxt, ctl2_r;
  logic signed [32:0] c2_r [3];
  logic signed [15:0] mm2_r [3];
  logic signed [16:0] cq2_nxt, cq2_r;
  logic signed [17:0] tr_sum;

  assign tr_sum = 18'(m_r[0]) + 18'(m_r[4]) + 18'(m_r[8]) - 18'sd16384;

  always_comb begin
    // clamp (trace-1)/2 to [-1, 1] in Q15
    if (tr_sum > 18'sd32768) begin
      cq2_nxt = 17'sd32768;
    end else if (tr_sum < -18'sd32768) begin
      cq2_nxt = -17'sd32768;
    end else begin
      cq2_nxt = tr_sum[16:0];
    end
    ctl2_nxt       = '0;
    ctl2_nxt.valid = v1_r;
    ctl2_nxt.mode  = MODE_DIV;
    ctl2_nxt.dx    = 17'(m_r[7]) - 17'(m_r[5]);
    ctl2_nxt.dy    = 17'(m_r[2]) - 17'(m_r[6]);
    ctl2_nxt.dz    = 17'(m_r[3]) - 17'(m_r[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r.valid <= 1'b0;
    end else if (en) begin
      ctl2_r <= ctl2_nxt;
    end
    if (en) begin
      c2_r[0]  <= 33'(p_r[0]) - 33'(p_r[1]);
      c2_r[1]  <= 33'(p_r[2]) - 33'(p_r[3]);
      c2_r[2]  <= 33'(p_r[4]) - 33'(p_r[5]);
      mm2_r[0] <= m_r[0];
      mm2_r[1] <= m_r[1];
      mm2_r[2] <= m_r[2];
      cq2_r    <= cq2_nxt;
    end
  end

  // ------------------------- stage 3: cofactor terms, cosine at F bits
  rmrv_ctl_t            ctl3_r;
  logic signed [48:0]   t3_r [3];
  logic signed [CFW-1:0] cf3_r;
  logic signed [39:0]   cf_wide;

  assign cf_wide = (40'(cq2_r) <<< CSL) >>> CSR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r.valid <= 1'b0;
    end else if (en) begin
      ctl3_r <= ctl2_r;
    end
    if (en) begin
      t3_r[0] <= mm2_r[0] * c2_r[0];
      t3_r[1] <= mm2_r[1] * c2_r[1];
      t3_r[2] <= mm2_r[2] * c2_r[2];
      cf3_r   <= cf_wide[CFW-1:0];
    end
  end

  // ------------------------------ stage 4: determinant sum, cosine square
  rmrv_ctl_t              ctl4_r;
  logic signed [50:0]     det4_r;
  logic signed [2*F+3:0]  cf2_4_r;
  logic signed [CFW-1:0]  cf4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r.valid <= 1'b0;
    end else if (en) begin
      ctl4_r <= ctl3_r;
    end
    if (en) begin
      det4_r  <= 51'(t3_r[0]) - 51'(t3_r[1]) + 51'(t3_r[2]);
      cf2_4_r <= cf3_r * cf3_r;
      cf4_r   <= cf3_r;
    end
  end

  // --------------------------- stage 5: tolerance check, sine^2 radicand
  rmrv_ctl_t              ctl5_nxt, ctl5_r;
  logic signed [51:0]     dev;
  logic [51:0]            adev;
  logic signed [2*F+3:0]  rad_wide;
  logic [RADW-1:0]        rad5_r;
  logic signed [CFW-1:0]  cf5_r;

  assign dev      = 52'(det4_r) - (52'sd1 <<< 42);
  assign adev     = dev[51] ? 52'(-dev) : 52'(dev);
  assign rad_wide = ((2*F+4)'(1) <<< (2*F)) - cf2_4_r;

  always_comb begin
    ctl5_nxt      = ctl4_r;
    ctl5_nxt.fail = adev >= (52'(det_tol_r) << 28);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r.valid <= 1'b0;
    end else if (en) begin
      ctl5_r <= ctl5_nxt;
    end
    if (en) begin
      rad5_r <= rad_wide[RADW-1:0];
      cf5_r  <= cf4_r;
    end
  end

  // ------------------------------------- square root, one bit per cell
  rmrv_ctl_t             sq_ctl  [F+2];
  logic [RADW-1:0]       sq_rem  [F+2];
  logic [SFW-1:0]        sq_root [F+2];
  logic signed [CFW-1:0] sq_cf   [F+2];

  assign sq_ctl[0]  = ctl5_r;
  assign sq_rem[0]  = rad5_r;
  assign sq_root[0] = '0;
  assign sq_cf[0]   = cf5_r;

  for (genvar k = 0; k <= F; k++) begin : g_sqrt
    rmrv_sqrt_cell #(.FRAC_BITS(F), .BIT_POS(F - k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (sq_ctl[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .cf_i   (sq_cf[k]),
      .ctl_o  (sq_ctl[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .cf_o   (sq_cf[k+1])
    );
  end

  // ------------------------------------- CORDIC setup, quadrant fold
  rmrv_ctl_t            pre_ctl_nxt;
  logic signed [XW-1:0] pre_x, pre_y, pre_z;
  logic signed [CFW-1:0] cfs;
  logic [SFW-1:0]       sfs;

  rmrv_ctl_t            co_ctl [N+1];
  logic signed [XW-1:0] co_x   [N+1];
  logic signed [XW-1:0] co_y   [N+1];
  logic signed [XW-1:0] co_z   [N+1];
  logic [SFW-1:0]       co_sf  [N+1];

  assign cfs = sq_cf[F+1];
  assign sfs = sq_root[F+1];

  always_comb begin
    pre_ctl_nxt      = sq_ctl[F+1];
    pre_ctl_nxt.zs   = (sfs == '0);
    pre_ctl_nxt.cpos = !cfs[CFW-1] && (cfs != '0);
    // cosine negative: rotate by 90 degrees first so CORDIC converges
    if (cfs[CFW-1]) begin
      pre_x = XW'($signed({1'b0, sfs}));
      pre_y = -XW'(cfs);
      pre_z = HALF_PI;
    end else begin
      pre_x = XW'(cfs);
      pre_y = XW'($signed({1'b0, sfs}));
      pre_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      co_ctl[0].valid <= 1'b0;
    end else if (en) begin
      co_ctl[0] <= pre_ctl_nxt;
    end
    if (en) begin
      co_x[0]  <= pre_x;
      co_y[0]  <= pre_y;
      co_z[0]  <= pre_z;
      co_sf[0] <= sfs;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cordic
    rmrv_cordic_cell #(.FRAC_BITS(F), .SHIFT(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (co_ctl[k]),
      .x_i   (co_x[k]),
      .y_i   (co_y[k]),
      .z_i   (co_z[k]),
      .sf_i  (co_sf[k]),
      .ctl_o (co_ctl[k+1]),
      .x_o   (co_x[k+1]),
      .y_o   (co_y[k+1]),
      .z_o   (co_z[k+1]),
      .sf_o  (co_sf[k+1])
    );
  end

  // ------------------------- post 1: angle to Q13, pick the result case
  rmrv_ctl_t        p1_ctl_nxt, p1_ctl_r;
  logic [TW-1:0]    zc, th_wide;
  logic [15:0]      th13, p1_th_r;
  logic [SFW-1:0]   p1_sf_r;
  logic signed [XW-1:0] zf;

  assign zf      = co_z[N];
  assign zc      = zf[XW-1] ? '0 : TW'(zf);
  assign th_wide = ((zc + RND) >> SHR) << SHL;
  assign th13    = th_wide[15:0];

  always_comb begin
    p1_ctl_nxt = co_ctl[N];
    if (co_ctl[N].fail) begin
      p1_ctl_nxt.mode = MODE_FAIL;
    end else if (co_ctl[N].zs) begin
      p1_ctl_nxt.mode = co_ctl[N].cpos ? MODE_ZERO : MODE_SAT;
    end else if (17'(th13) < 17'(ang_eps_r)) begin
      p1_ctl_nxt.mode = MODE_ZERO;
    end else if (17'(th13) + 17'(ang_eps_r) > PI13) begin
      p1_ctl_nxt.mode = MODE_SAT;
    end else begin
      p1_ctl_nxt.mode = MODE_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_ctl_r.valid <= 1'b0;
    end else if (en) begin
      p1_ctl_r <= p1_ctl_nxt;
    end
    if (en) begin
      p1_th_r <= th13;
      p1_sf_r <= co_sf[N];
    end
  end

  // ------------------ post 2: numerators |d|*theta*2^F + den/2, divisor
  logic [16:0]          mag [3];
  logic [32:0]          prod [3];
  rmrv_ctl_t            dv_ctl [17];
  logic [2:0][NW-1:0]   dv_rem [17];
  logic [2:0][15:0]     dv_q   [17];
  logic [DW-1:0]        dv_den [17];

  assign mag[0] = p1_ctl_r.dx[16] ? 17'(-p1_ctl_r.dx) : 17'(p1_ctl_r.dx);
  assign mag[1] = p1_ctl_r.dy[16] ? 17'(-p1_ctl_r.dy) : 17'(p1_ctl_r.dy);
  assign mag[2] = p1_ctl_r.dz[16] ? 17'(-p1_ctl_r.dz) : 17'(p1_ctl_r.dz);

  for (genvar k = 0; k < 3; k++) begin : g_prod
    assign prod[k] = 33'(mag[k]) * 33'(p1_th_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_ctl[0].valid <= 1'b0;
    end else if (en) begin
      dv_ctl[0] <= p1_ctl_r;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k] <= (NW'(prod[k]) << F) + (NW'(p1_sf_r) << 14);
      end
      dv_q[0]   <= '0;
      dv_den[0] <= DW'(p1_sf_r) << 15;
    end
  end

  // Quotient bit 15 set means |rot| >= 32768: saturate, lower bits unused.
  for (genvar k = 0; k < 16; k++) begin : g_div
    rmrv_div_cell #(.FRAC_BITS(F), .BIT_POS(15 - k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (dv_ctl[k]),
      .rem_i (dv_rem[k]),
      .q_i   (dv_q[k]),
      .den_i (dv_den[k]),
      .ctl_o (dv_ctl[k+1]),
      .rem_o (dv_rem[k+1]),
      .q_o   (dv_q[k+1]),
      .den_o (dv_den[k+1])
    );
  end

  // ------------------------------------------------ output register
  rmrv_ctl_t          fc;
  logic signed [16:0] fd [3];
  logic signed [15:0] rot_nxt [3];
  logic signed [15:0] rot_r [3];
  logic [1:0]         status_nxt, status_r;

  assign fc    = dv_ctl[16];
  assign fd[0] = fc.dx;
  assign fd[1] = fc.dy;
  assign fd[2] = fc.dz;

  always_comb begin
    status_nxt = STATUS_OK;
    for (int k = 0; k < 3; k++) begin
      rot_nxt[k] = '0;
    end
    case (fc.mode)
      MODE_FAIL: begin
        status_nxt = STATUS_DET;
      end
      MODE_ZERO: begin
        status_nxt = STATUS_OK;
      end
      MODE_SAT: begin
        status_nxt = STATUS_PI;
        for (int k = 0; k < 3; k++) begin
          if (fd[k] > 17'sd0) begin
            rot_nxt[k] = ROT_MAX;
          end else if (fd[k] < 17'sd0) begin
            rot_nxt[k] = ROT_MIN;
          end
        end
      end
      MODE_DIV: begin
        for (int k = 0; k < 3; k++) begin
          if (dv_q[16][k][15]) begin
            rot_nxt[k] = fd[k][16] ? ROT_MIN : ROT_MAX;
          end else if (fd[k][16]) begin
            rot_nxt[k] = -$signed(dv_q[16][k]);
          end else begin
            rot_nxt[k] = $signed(dv_q[16][k]);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= fc.valid;
    end
    if (en) begin
      rot_r    <= rot_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.rot_x  = rot_r[0];
  assign out_ch.rot_y  = rot_r[1];
  assign out_ch.rot_z  = rot_r[2];
  assign out_ch.status = status_r;

  // ---------------------------------------------------------- assertions
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted transaction did not enter stage 1");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == STATUS_OK || out_ch.status == STATUS_DET ||
                      out_ch.status == STATUS_PI))
    else $error("undefined status code");

  a_det_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == STATUS_DET |->
      out_ch.rot_x == 16'sd0 && out_ch.rot_y == 16'sd0 && out_ch.rot_z == 16'sd0)
    else $error("determinant failure with nonzero vector");

  a_pi_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == STATUS_PI |->
      (out_ch.rot_x == ROT_MAX || out_ch.rot_x == ROT_MIN || out_ch.rot_x == 16'sd0) &&
      (out_ch.rot_y == ROT_MAX || out_ch.rot_y == ROT_MIN || out_ch.rot_y == 16'sd0) &&
      (out_ch.rot_z == ROT_MAX || out_ch.rot_z == ROT_MIN || out_ch.rot_z == 16'sd0))
    else $error("near-pi result not saturated");

endmodule

`default_nettype wire

// File: rtl/rmrv_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rmrv_sqrt_cell
// One result bit of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrv_sqrt_cell import rmrv_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int BIT_POS   = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire rmrv_ctl_t                 ctl_i,
  input  wire logic [2*FRAC_BITS:0]      rem_i,
  input  wire logic [FRAC_BITS:0]        root_i,
  input  wire logic signed [FRAC_BITS+1:0] cf_i,
  output rmrv_ctl_t                      ctl_o,
  output logic [2*FRAC_BITS:0]           rem_o,
  output logic [FRAC_BITS:0]             root_o,
  output logic signed [FRAC_BITS+1:0]    cf_o
);

  localparam int RW = 2*FRAC_BITS + 1;
  localparam int SW = FRAC_BITS + 1;
  localparam int TW = 2*FRAC_BITS + 3;

  rmrv_ctl_t               ctl_r;
  logic [RW-1:0]           rem_r;
  logic [SW-1:0]           root_r;
  logic signed [SW:0]      cf_r;
  logic [TW-1:0]           trial;
  logic                    take;

  // try setting this bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
  assign trial = (TW'(root_i) << (BIT_POS + 1)) + (TW'(1) << (2*BIT_POS));
  assign take  = TW'(rem_i) >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
    if (en) begin
      rem_r  <= take ? rem_i - RW'(trial) : rem_i;
      root_r <= take ? (root_i | (SW'(1) << BIT_POS)) : root_i;
      cf_r   <= cf_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign cf_o   = cf_r;

endmodule

`default_nettype wire

// File: rtl/rmrv_cordic_cell.sv
// ----------------------------------------------------------------------------
// rmrv_cordic_cell
// One vectoring CORDIC micro-rotation with its fixed shift and angle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrv_cordic_cell import rmrv_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int SHIFT     = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire rmrv_ctl_t                 ctl_i,
  input  wire logic signed [FRAC_BITS+3:0] x_i,
  input  wire logic signed [FRAC_BITS+3:0] y_i,
  input  wire logic signed [FRAC_BITS+3:0] z_i,
  input  wire logic [FRAC_BITS:0]        sf_i,
  output rmrv_ctl_t                      ctl_o,
  output logic signed [FRAC_BITS+3:0]    x_o,
  output logic signed [FRAC_BITS+3:0]    y_o,
  output logic signed [FRAC_BITS+3:0]    z_o,
  output logic [FRAC_BITS:0]             sf_o
);

  localparam int XW = FRAC_BITS + 4;
  localparam logic signed [XW-1:0] ANG = XW'(atan_f(SHIFT, FRAC_BITS));

  rmrv_ctl_t             ctl_r;
  logic signed [XW-1:0]  x_r, y_r, z_r;
  logic [FRAC_BITS:0]    sf_r;
  logic signed [XW-1:0]  xs, ys;

  assign xs = x_i >>> SHIFT;
  assign ys = y_i >>> SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
    if (en) begin
      // drive y toward zero, accumulate the angle in z
      if (!y_i[XW-1]) begin
        x_r <= x_i + ys;
        y_r <= y_i - xs;
        z_r <= z_i + ANG;
      end else begin
        x_r <= x_i - ys;
        y_r <= y_i + xs;
        z_r <= z_i - ANG;
      end
      sf_r <= sf_i;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign sf_o  = sf_r;

endmodule

`default_nettype wire

// File: rtl/rmrv_div_cell.sv
// ----------------------------------------------------------------------------
// rmrv_div_cell
// One quotient bit of restoring division for all three axis lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrv_div_cell import rmrv_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int BIT_POS   = 0
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire rmrv_ctl_t                      ctl_i,
  input  wire logic [2:0][FRAC_BITS+34:0]     rem_i,
  input  wire logic [2:0][15:0]               q_i,
  input  wire logic [FRAC_BITS+15:0]          den_i,
  output rmrv_ctl_t                           ctl_o,
  output logic [2:0][FRAC_BITS+34:0]          rem_o,
  output logic [2:0][15:0]                    q_o,
  output logic [FRAC_BITS+15:0]               den_o
);

  localparam int NW = FRAC_BITS + 35;

  rmrv_ctl_t              ctl_r;
  logic [2:0][NW-1:0]     rem_r;
  logic [2:0][15:0]       q_r;
  logic [FRAC_BITS+15:0]  den_r;
  logic [NW-1:0]          dsh;

  assign dsh = NW'(den_i) << BIT_POS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (rem_i[k] >= dsh) begin
          rem_r[k] <= rem_i[k] - dsh;
          q_r[k]   <= q_i[k] | (16'd1 << BIT_POS);
        end else begin
          rem_r[k] <= rem_i[k];
          q_r[k]   <= q_i[k];
        end
      end
      den_r <= den_i;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;
  assign den_o = den_r;

endmodule

`default_nettype wire
